@@ rtl/core/nrdiv_pkg.sv @@
// Shared types and constants of the non-restoring integer divider.
package nrdiv_pkg;

   // Operand and result width of the divider.
   localparam int DATA_WIDTH = 32;
   // Partial remainder width: sign bit plus one guard bit above the data.
   localparam int REM_WIDTH  = DATA_WIDTH + 2;
   // Iteration counter width.
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);
   // Last iteration index.
   localparam logic [CNT_WIDTH-1:0] LAST_ITER = CNT_WIDTH'(DATA_WIDTH - 1);

   // Function code bit positions.
   localparam int FUNC_REM_BIT    = 0;
   localparam int FUNC_SIGNED_BIT = 1;

   // Datapath step selected by the sequencer in the current cycle.
   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_LOAD,
      STEP_NEG_A,
      STEP_NEG_B,
      STEP_ITER,
      STEP_CORR,
      STEP_FIX
   } step_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEG_A,
      ST_NEG_B,
      ST_ITER,
      ST_CORR,
      ST_FIX
   } state_type;

   // Control word from the sequencer to the datapath.
   typedef struct packed {
      step_type step;
   } ctrl_type;

endpackage

@@ rtl/core/nrdiv_ctrl.sv @@
// Sequencer of the divider: walks one word through load, sign, iterate, correct and fix-up steps.
module nrdiv_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               out_busy,
   output logic               req_stall,
   output nrdiv_pkg::ctrl_type ctrl
);

   nrdiv_pkg::state_type                state_ff, state_in;
   logic [nrdiv_pkg::CNT_WIDTH-1:0]     cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nrdiv_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_stall = 1'b1;
      ctrl.step = nrdiv_pkg::STEP_IDLE;
      case (state_ff)
         nrdiv_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cnt_in    = '0;
            if (req_valid) begin
               ctrl.step = nrdiv_pkg::STEP_LOAD;
               state_in  = nrdiv_pkg::ST_NEG_A;
            end
         end
         nrdiv_pkg::ST_NEG_A: begin
            ctrl.step = nrdiv_pkg::STEP_NEG_A;
            state_in  = nrdiv_pkg::ST_NEG_B;
         end
         nrdiv_pkg::ST_NEG_B: begin
            ctrl.step = nrdiv_pkg::STEP_NEG_B;
            state_in  = nrdiv_pkg::ST_ITER;
         end
         nrdiv_pkg::ST_ITER: begin
            ctrl.step = nrdiv_pkg::STEP_ITER;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == nrdiv_pkg::LAST_ITER) begin
               state_in = nrdiv_pkg::ST_CORR;
            end
         end
         nrdiv_pkg::ST_CORR: begin
            ctrl.step = nrdiv_pkg::STEP_CORR;
            state_in  = nrdiv_pkg::ST_FIX;
         end
         nrdiv_pkg::ST_FIX: begin
            // Wait here until the output register can take the word.
            if (!out_busy) begin
               ctrl.step = nrdiv_pkg::STEP_FIX;
               state_in  = nrdiv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nrdiv_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/nrdiv_dp.sv @@
// Datapath of the divider: operand registers around one shared add/subtract unit.
module nrdiv_dp (
   input  logic                             clock,
   input  nrdiv_pkg::ctrl_type              ctrl,
   input  logic [1:0]                       req_func,
   input  logic [nrdiv_pkg::DATA_WIDTH-1:0] req_dividend,
   input  logic [nrdiv_pkg::DATA_WIDTH-1:0] req_divisor,
   output logic [nrdiv_pkg::DATA_WIDTH-1:0] fix_result,
   output logic                             fix_dz
);

   localparam int W  = nrdiv_pkg::DATA_WIDTH;
   localparam int RW = nrdiv_pkg::REM_WIDTH;

   logic [RW-1:0] rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  div_ff, div_in;
   logic          want_rem_ff, want_rem_in;
   logic          neg_a_ff, neg_a_in;
   logic          neg_b_ff, neg_b_in;
   logic          signed_ff, signed_in;
   logic          dz_ff, dz_in;

   logic [RW-1:0] add_a, add_b, add_sum;
   logic          add_sub;
   logic [W-1:0]  res_sel;
   logic          fix_neg;

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_ff      <= div_in;
      want_rem_ff <= want_rem_in;
      neg_a_ff    <= neg_a_in;
      neg_b_ff    <= neg_b_in;
      signed_ff   <= signed_in;
      dz_ff       <= dz_in;
   end

   // The single shared adder; subtraction inverts the second operand and carries in one.
   assign add_sum = add_a + (add_b ^ {RW{add_sub}}) + RW'(add_sub);

   assign res_sel = want_rem_ff ? rem_ff[W-1:0] : quo_ff;

   // A remainder takes the dividend's sign. A quotient is negated when the signs differ,
   // except on a zero divisor, where it stays all ones.
   assign fix_neg = signed_ff &
                    (want_rem_ff ? neg_a_ff : ((neg_a_ff ^ neg_b_ff) & ~dz_ff));

   assign fix_result = add_sum[W-1:0];
   assign fix_dz     = dz_ff;

   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      case (ctrl.step)
         nrdiv_pkg::STEP_NEG_A: begin
            add_b   = {2'b00, quo_ff};
            add_sub = 1'b1;
         end
         nrdiv_pkg::STEP_NEG_B: begin
            add_b   = {2'b00, div_ff};
            add_sub = 1'b1;
         end
         nrdiv_pkg::STEP_ITER: begin
            add_a   = {rem_ff[RW-2:0], quo_ff[W-1]};
            add_b   = {2'b00, div_ff};
            add_sub = ~rem_ff[RW-1];
         end
         nrdiv_pkg::STEP_CORR: begin
            add_a = rem_ff;
            add_b = {2'b00, div_ff};
         end
         nrdiv_pkg::STEP_FIX: begin
            add_b   = {2'b00, res_sel};
            add_sub = fix_neg;
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   always_comb begin
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      div_in      = div_ff;
      want_rem_in = want_rem_ff;
      neg_a_in    = neg_a_ff;
      neg_b_in    = neg_b_ff;
      signed_in   = signed_ff;
      dz_in       = dz_ff;
      case (ctrl.step)
         nrdiv_pkg::STEP_LOAD: begin
            rem_in      = '0;
            quo_in      = req_dividend;
            div_in      = req_divisor;
            want_rem_in = req_func[nrdiv_pkg::FUNC_REM_BIT];
            signed_in   = req_func[nrdiv_pkg::FUNC_SIGNED_BIT];
            neg_a_in    = req_func[nrdiv_pkg::FUNC_SIGNED_BIT] & req_dividend[W-1];
            neg_b_in    = req_func[nrdiv_pkg::FUNC_SIGNED_BIT] & req_divisor[W-1];
            dz_in       = (req_divisor == '0);
         end
         nrdiv_pkg::STEP_NEG_A: begin
            if (neg_a_ff) begin
               quo_in = add_sum[W-1:0];
            end
         end
         nrdiv_pkg::STEP_NEG_B: begin
            if (neg_b_ff) begin
               div_in = add_sum[W-1:0];
            end
         end
         nrdiv_pkg::STEP_ITER: begin
            rem_in = add_sum;
            quo_in = {quo_ff[W-2:0], ~add_sum[RW-1]};
         end
         nrdiv_pkg::STEP_CORR: begin
            if (rem_ff[RW-1]) begin
               rem_in = add_sum;
            end
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

endmodule

@@ rtl/core/nonrestoring_int_divider_core.sv @@
// Top level of the radix-2 non-restoring integer divider with its output register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_func, req_dividend, req_divisor
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_result, rsp_divide_by_zero
//
// A word is taken in the idle state and then occupies the shared adder for these steps:
// one to negate the dividend, one to negate the divisor, 32 quotient-bit iterations,
// one remainder correction and one sign fix-up that writes the output register.
// No new word is accepted until the sequencer is back in the idle state, after the
// fix-up step of the last word.
// Reset is synchronous and clears only the sequencer and the output valid flag.
// While a finished word sits stalled in the output register the next word is still
// worked on; it waits in its final step until the register is free.
module nonrestoring_int_divider_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_func,
   input  logic [nrdiv_pkg::DATA_WIDTH-1:0] req_dividend,
   input  logic [nrdiv_pkg::DATA_WIDTH-1:0] req_divisor,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [nrdiv_pkg::DATA_WIDTH-1:0] rsp_result,
   output logic                             rsp_divide_by_zero
);

   nrdiv_pkg::ctrl_type                 ctrl;
   logic [nrdiv_pkg::DATA_WIDTH-1:0]    fix_result;
   logic                                fix_dz;
   logic                                out_busy;
   logic                                out_write;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [nrdiv_pkg::DATA_WIDTH-1:0]    rsp_result_ff, rsp_result_in;
   logic                                rsp_dz_ff, rsp_dz_in;

   // The output register is busy only while it holds a word the receiver is stalling.
   assign out_busy  = rsp_valid_ff & rsp_stall;
   assign out_write = (ctrl.step == nrdiv_pkg::STEP_FIX);

   nrdiv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .req_stall (req_stall),
      .ctrl      (ctrl)
   );

   nrdiv_dp u_dp (
      .clock        (clock),
      .ctrl         (ctrl),
      .req_func     (req_func),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .fix_result   (fix_result),
      .fix_dz       (fix_dz)
   );

   // The sign fix-up result goes straight into the output register; the valid flag
   // drops once the receiver takes the word and no new one is written.
   always_comb begin
      rsp_valid_in  = out_write | (rsp_valid_ff & rsp_stall);
      rsp_result_in = out_write ? fix_result : rsp_result_ff;
      rsp_dz_in     = out_write ? fix_dz : rsp_dz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      rsp_dz_ff     <= rsp_dz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule
